// ===== rtl/hpt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants of the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_REGS      = 8;
	localparam int CFG_IDX_W     = 4;
	localparam int CFG_DATA_W    = 64;
	localparam int COORD_W       = 32;
	localparam int SUM_W         = 66;
	localparam int MAG_W         = 66;
	localparam int QUO_W         = 32;
	localparam int REM_W         = MAG_W + QUO_W + 1;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_W_ZERO = 2'd1;
	localparam logic [1:0] STATUS_SAT    = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] result_x;
		logic signed [COORD_W-1:0] result_y;
		logic signed [COORD_W-1:0] result_z;
		logic [1:0]                status;
	} result_t;

	typedef struct packed {
		logic                        valid;
		logic [2:0][MAG_W-1:0]       num;
		logic [2:0]                  neg;
		logic [MAG_W-1:0]            den;
		logic                        wzero;
	} div_in_t;

endpackage

`default_nettype wire

// ===== rtl/hpt_divide.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_divide
// Pipelined restoring divider for three lanes sharing one denominator,
// one quotient bit per stage, with saturation and final sign.
// ----------------------------------------------------------------------------
module hpt_divide #(
	parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  hpt_pkg::div_in_t     din,
	output logic                 done,
	output hpt_pkg::result_t     result
);
	import hpt_pkg::*;

	typedef struct packed {
		logic [2:0][REM_W-1:0] rem;
		logic [2:0][QUO_W-1:0] quo;
		logic [2:0]            neg;
		logic [2:0]            big;
		logic [MAG_W-1:0]      den;
		logic                  wzero;
	} stage_t;

	stage_t     stg_s [0:QUO_W];
	logic       vld_s [0:QUO_W];
	stage_t     pre;

	always_comb begin
		pre.den   = din.den;
		pre.wzero = din.wzero;
		pre.neg   = din.neg;
		for (int l = 0; l < 3; l++) begin
			pre.rem[l] = REM_W'(din.num[l]) << FRAC_BITS;
			pre.quo[l] = '0;
			pre.big[l] = (REM_W'(din.num[l]) << FRAC_BITS) >= (REM_W'(din.den) << QUO_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		stg_s[0] <= pre;
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		stage_t nxt;
		logic [REM_W-1:0] dsh;

		always_comb begin
			dsh = REM_W'(stg_s[k].den) << (QUO_W - 1 - k);
			nxt = stg_s[k];
			for (int l = 0; l < 3; l++) begin
				if (stg_s[k].rem[l] >= dsh) begin
					nxt.rem[l] = stg_s[k].rem[l] - dsh;
					nxt.quo[l] = {stg_s[k].quo[l][QUO_W-2:0], 1'b1};
				end else begin
					nxt.quo[l] = {stg_s[k].quo[l][QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			stg_s[k+1] <= nxt;
		end
	end

	result_t          fin;
	logic [2:0]       sat;
	logic [2:0][QUO_W-1:0] val;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			logic [QUO_W-1:0] limit;
			logic [QUO_W-1:0] mag;
			limit = stg_s[QUO_W].neg[l] ? {1'b1, {(QUO_W-1){1'b0}}}
			                            : {1'b0, {(QUO_W-1){1'b1}}};
			sat[l] = stg_s[QUO_W].big[l] || (stg_s[QUO_W].quo[l] > limit);
			mag    = sat[l] ? limit : stg_s[QUO_W].quo[l];
			val[l] = stg_s[QUO_W].neg[l] ? (~mag + 1'b1) : mag;
		end
		if (stg_s[QUO_W].wzero) begin
			fin.result_x = '0;
			fin.result_y = '0;
			fin.result_z = '0;
			fin.status   = STATUS_W_ZERO;
		end else begin
			fin.result_x = $signed(val[0]);
			fin.result_y = $signed(val[1]);
			fin.result_z = $signed(val[2]);
			fin.status   = (|sat) ? STATUS_SAT : STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		result <= fin;
	end

endmodule

`default_nettype wire

// ===== rtl/homogeneous_point_transform.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 matrix transform of a fixed-point point with divide by w.
//
//   channel   signals                       handshake
//   input     start, busy, point            accepted when start && !busy
//   result    done, result                  one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_index, cfg_data   written when cfg_we, index < 8
//
// One item per clock; busy is always low. The result strobe follows the edge
// that takes the item through input, multiply, sum, magnitude and range
// stages, the 32-stage quotient pipeline and an output stage, which the
// receiver cannot stall. Reset clears valid bits, loads the identity matrix.
// ----------------------------------------------------------------------------
module homogeneous_point_transform #(
	parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  hpt_pkg::point_t                   point,
	output logic                              done,
	output hpt_pkg::result_t                  result,
	input  wire                               cfg_we,
	input  wire  [hpt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [hpt_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import hpt_pkg::*;

	localparam logic [CFG_DATA_W-1:0] ONE_LO = CFG_DATA_W'(1) << FRAC_BITS;
	localparam logic [CFG_DATA_W-1:0] ONE_HI = CFG_DATA_W'(1) << (FRAC_BITS + 32);
	localparam logic [NUM_REGS-1:0][CFG_DATA_W-1:0] CFG_RESET = {
		ONE_HI, CFG_DATA_W'(0), ONE_LO, CFG_DATA_W'(0),
		CFG_DATA_W'(0), ONE_HI, CFG_DATA_W'(0), ONE_LO
	};

	logic [NUM_REGS-1:0][CFG_DATA_W-1:0] cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	function automatic logic signed [COORD_W-1:0] ent(
		input logic [NUM_REGS-1:0][CFG_DATA_W-1:0] regs,
		input int e
	);
		ent = $signed(regs[e >> 1][(e & 1) * 32 +: 32]);
	endfunction

	assign busy = 1'b0;

	point_t                     pt_s1;
	logic                       v_s1, v_s2, v_s3;
	logic signed [63:0]         prod_s2 [0:3][0:2];
	logic signed [SUM_W-1:0]    sum_s3 [0:3];
	div_in_t                    div_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		pt_s1 <= point;
		for (int r = 0; r < 4; r++) begin
			prod_s2[r][0] <= 64'(ent(cfg_q, r))     * 64'(pt_s1.point_x);
			prod_s2[r][1] <= 64'(ent(cfg_q, 4 + r)) * 64'(pt_s1.point_y);
			prod_s2[r][2] <= 64'(ent(cfg_q, 8 + r)) * 64'(pt_s1.point_z);
		end
		for (int r = 0; r < 4; r++) begin
			sum_s3[r] <= SUM_W'(prod_s2[r][0]) + SUM_W'(prod_s2[r][1])
			           + SUM_W'(prod_s2[r][2])
			           + (SUM_W'(ent(cfg_q, 12 + r)) <<< FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s4 <= '0;
		end else begin
			div_s4.valid <= v_s3;
			for (int l = 0; l < 3; l++) begin
				div_s4.neg[l] <= sum_s3[l][SUM_W-1] ^ sum_s3[3][SUM_W-1];
				div_s4.num[l] <= sum_s3[l][SUM_W-1] ? MAG_W'(-sum_s3[l]) : MAG_W'(sum_s3[l]);
			end
			div_s4.den   <= sum_s3[3][SUM_W-1] ? MAG_W'(-sum_s3[3]) : MAG_W'(sum_s3[3]);
			div_s4.wzero <= (sum_s3[3] == '0);
		end
	end

	hpt_divide #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (div_s4),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire
